/* hw/rtl/via_pkg.sv */
package via_pkg;

  // item kinds
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_PB6   = 2'd3
  } req_type_t;

  // register map
  localparam logic [3:0] ADDR_ORB    = 4'd0;
  localparam logic [3:0] ADDR_ORA    = 4'd1;
  localparam logic [3:0] ADDR_DDRB   = 4'd2;
  localparam logic [3:0] ADDR_DDRA   = 4'd3;
  localparam logic [3:0] ADDR_T1CL   = 4'd4;
  localparam logic [3:0] ADDR_T1CH   = 4'd5;
  localparam logic [3:0] ADDR_T1LL   = 4'd6;
  localparam logic [3:0] ADDR_T1LH   = 4'd7;
  localparam logic [3:0] ADDR_T2CL   = 4'd8;
  localparam logic [3:0] ADDR_T2CH   = 4'd9;
  localparam logic [3:0] ADDR_SR     = 4'd10;
  localparam logic [3:0] ADDR_ACR    = 4'd11;
  localparam logic [3:0] ADDR_PCR    = 4'd12;
  localparam logic [3:0] ADDR_IFR    = 4'd13;
  localparam logic [3:0] ADDR_IER    = 4'd14;
  localparam logic [3:0] ADDR_ORA_NH = 4'd15;

  // flag register bit positions
  localparam int IFR_T1 = 6;
  localparam int IFR_T2 = 5;
  localparam int IFR_SR = 2;

  // aux control bit positions
  localparam int ACR_FREE  = 6;
  localparam int ACR_PULSE = 5;

  // timer 1 status bits
  localparam int T1_RUN  = 0;
  localparam int T1_ARM  = 1;
  localparam int T1_PEND = 2;
  localparam int T1_JUST = 3;
  localparam int T1_HOLD = 4;

  // timer 2 status bits
  localparam int T2_RUN  = 0;
  localparam int T2_ARM  = 1;
  localparam int T2_JUST = 2;

  localparam logic [15:0] CNT_PARK = 16'hFFFF;

  typedef struct packed {
    req_type_t   req_type;
    logic [3:0]  reg_addr;
    logic [7:0]  write_data;
    logic [7:0]  port_a_pins;
    logic        pb6_in;
  } via_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
  } via_result_t;

endpackage

/* hw/rtl/via_if.sv */
interface via_req_if;
  logic                valid;
  logic                ready;
  via_pkg::req_type_t  req_type;
  logic [3:0]          reg_addr;
  logic [7:0]          write_data;
  logic [7:0]          port_a_pins;
  logic                pb6_in;

  modport source (output valid, req_type, reg_addr, write_data, port_a_pins, pb6_in,
                  input ready);
  modport sink   (input valid, req_type, reg_addr, write_data, port_a_pins, pb6_in,
                  output ready);
endinterface

interface via_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_out;

  modport source (output valid, read_data, irq_out, input ready);
  modport sink   (input valid, read_data, irq_out, output ready);
endinterface

/* hw/rtl/versatile_interface_adapter_timers.sv */
// Two-timer interface adapter register file (6522-style register map).
// in_req carries one beat per item: a register read, a register write, one
// clock tick for the timers, or a new PB6 pin level. out_rsp returns exactly
// one beat per item, in order: read_data (register value for reads, zero
// otherwise) and irq_out (interrupt request after the item).
// Timing: a beat accepted by in_req is registered in the input stage; its state
// update and result are computed combinationally from that stage, and the result
// is registered into the output stage when the input stage advances, which sets
// out_rsp.valid.
// Throughput: one item per cycle while out_rsp.ready is high. The register and
// timer update is a single pass of logic between the input and output stages.
// Stall: when out_rsp.ready is low the output beat holds, the input stage
// holds its item and in_req.ready drops once the input stage is full.
// Reset (rst_n low, synchronous): both stages empty, registers take their
// power-on values (ORB 0xFF, counters 0xFFFF, PB6 seen high, rest zero),
// timers stopped until their high counter byte is written.
module versatile_interface_adapter_timers (
  input logic      clk,
  input logic      rst_n,
  via_req_if.sink  in_req,
  via_rsp_if.source out_rsp
);
  import via_pkg::*;

  // input stage
  logic        s1_valid_r;
  via_item_t   s1_item_r;
  // output stage
  logic        out_valid_r;
  via_result_t out_res_r;

  logic        s1_adv;      // input stage hands its item to the output stage
  via_result_t core_res;

  // output stage can take a beat when empty or being drained
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_item_r.req_type    <= in_req.req_type;
      s1_item_r.reg_addr    <= in_req.reg_addr;
      s1_item_r.write_data  <= in_req.write_data;
      s1_item_r.port_a_pins <= in_req.port_a_pins;
      s1_item_r.pb6_in      <= in_req.pb6_in;
    end
  end

  // register file and timers, state commits as the item moves on
  via_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s1_adv),
    .item   (s1_item_r),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.read_data = out_res_r.read_data;
  assign out_rsp.irq_out   = out_res_r.irq_out;

  // a stalled input stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage dropped a stalled item");

  // anything but a read returns zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.req_type != REQ_READ) |=> out_valid_r && out_res_r.read_data == 8'h00)
    else $error("non-read item returned data");

  // an empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_req.ready)
    else $error("input stalled with empty output stage");

endmodule

/* hw/rtl/via_regs.sv */
module via_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  via_pkg::via_item_t   item,
  output via_pkg::via_result_t result
);
  import via_pkg::*;

  logic [7:0]  orb_r, orb_nxt, ora_r, ora_nxt, ddrb_r, ddrb_nxt, ddra_r, ddra_nxt;
  logic [15:0] t1_reload_r, t1_reload_nxt, t1_cnt_r, t1_cnt_nxt;
  logic [4:0]  t1_flags_r, t1_flags_nxt;
  logic [8:0]  t1_snap_r, t1_snap_nxt;
  logic [15:0] t2_reload_r, t2_reload_nxt, t2_cnt_r, t2_cnt_nxt;
  logic [2:0]  t2_flags_r, t2_flags_nxt;
  logic [7:0]  acr_r, acr_nxt, pcr_r, pcr_nxt, sr_r, sr_nxt;
  logic [6:0]  ifr_r, ifr_nxt, ier_r, ier_nxt;
  logic        pb6_last_r, pb6_last_nxt;
  logic        irq_cur;
  logic [7:0]  rd;

  function automatic logic irq_calc(logic [6:0] ifr, logic [6:0] ier, logic hold);
    logic [6:0] act;
    act = ifr & ier;
    if (hold) act[IFR_T1] = 1'b0;
    return |act;
  endfunction

  assign irq_cur = irq_calc(ifr_r, ier_r, t1_flags_r[T1_HOLD]);

  always_comb begin
    orb_nxt       = orb_r;
    ora_nxt       = ora_r;
    ddrb_nxt      = ddrb_r;
    ddra_nxt      = ddra_r;
    t1_reload_nxt = t1_reload_r;
    t1_cnt_nxt    = t1_cnt_r;
    t1_flags_nxt  = t1_flags_r;
    t1_snap_nxt   = t1_snap_r;
    t2_reload_nxt = t2_reload_r;
    t2_cnt_nxt    = t2_cnt_r;
    t2_flags_nxt  = t2_flags_r;
    acr_nxt       = acr_r;
    pcr_nxt       = pcr_r;
    sr_nxt        = sr_r;
    ifr_nxt       = ifr_r;
    ier_nxt       = ier_r;
    pb6_last_nxt  = pb6_last_r;
    rd            = 8'h00;

    unique case (item.req_type)
      REQ_READ: begin
        unique case (item.reg_addr)
          ADDR_ORB:  rd = orb_r;
          ADDR_ORA, ADDR_ORA_NH: rd = (ora_r & ddra_r) | (item.port_a_pins & ~ddra_r);
          ADDR_DDRB: rd = ddrb_r;
          ADDR_DDRA: rd = ddra_r;
          ADDR_T1CL: begin
            t1_snap_nxt     = {1'b1, t1_cnt_r[15:8]};
            ifr_nxt[IFR_T1] = 1'b0;
            rd              = t1_cnt_r[7:0];
          end
          ADDR_T1CH: begin
            if (t1_snap_r[8]) begin
              rd             = t1_snap_r[7:0];
              t1_snap_nxt[8] = 1'b0;
            end else begin
              rd = t1_cnt_r[15:8];
            end
          end
          ADDR_T1LL: rd = t1_reload_r[7:0];
          ADDR_T1LH: rd = t1_reload_r[15:8];
          ADDR_T2CL: begin
            ifr_nxt[IFR_T2] = 1'b0;
            rd              = t2_cnt_r[7:0];
          end
          ADDR_T2CH: rd = t2_cnt_r[15:8];
          ADDR_SR: begin
            ifr_nxt[IFR_SR] = 1'b0;
            rd              = sr_r;
          end
          ADDR_ACR:  rd = acr_r;
          ADDR_PCR:  rd = pcr_r;
          ADDR_IFR:  rd = {irq_cur, ifr_r};
          ADDR_IER:  rd = {1'b1, ier_r};
        endcase
      end

      REQ_WRITE: begin
        unique case (item.reg_addr)
          ADDR_ORB:  orb_nxt = item.write_data;
          ADDR_ORA, ADDR_ORA_NH: ora_nxt = item.write_data;
          ADDR_DDRB: ddrb_nxt = item.write_data;
          ADDR_DDRA: ddra_nxt = item.write_data;
          ADDR_T1CL, ADDR_T1LL: t1_reload_nxt[7:0] = item.write_data;
          ADDR_T1CH: begin
            t1_reload_nxt[15:8]   = item.write_data;
            t1_cnt_nxt            = {item.write_data, t1_reload_r[7:0]};
            t1_flags_nxt          = '0;
            t1_flags_nxt[T1_RUN]  = 1'b1;
            t1_flags_nxt[T1_ARM]  = 1'b1;
            t1_flags_nxt[T1_JUST] = 1'b1;
            t1_snap_nxt[8]        = 1'b0;
            ifr_nxt[IFR_T1]       = 1'b0;
          end
          ADDR_T1LH: begin
            t1_reload_nxt[15:8] = item.write_data;
            ifr_nxt[IFR_T1]     = 1'b0;
          end
          ADDR_T2CL: t2_reload_nxt[7:0] = item.write_data;
          ADDR_T2CH: begin
            t2_reload_nxt[15:8]   = item.write_data;
            t2_cnt_nxt            = {item.write_data, t2_reload_r[7:0]};
            t2_flags_nxt          = '0;
            t2_flags_nxt[T2_RUN]  = 1'b1;
            t2_flags_nxt[T2_ARM]  = 1'b1;
            t2_flags_nxt[T2_JUST] = 1'b1;
            ifr_nxt[IFR_T2]       = 1'b0;
          end
          ADDR_SR:   sr_nxt = item.write_data;
          ADDR_ACR:  acr_nxt = item.write_data;
          ADDR_PCR:  pcr_nxt = item.write_data;
          ADDR_IFR:  ifr_nxt = ifr_r & ~item.write_data[6:0];
          ADDR_IER: begin
            if (item.write_data[7]) ier_nxt = ier_r | item.write_data[6:0];
            else ier_nxt = ier_r & ~item.write_data[6:0];
          end
        endcase
      end

      REQ_TICK: begin
        t1_flags_nxt[T1_HOLD] = 1'b0;
        // timer 1
        if (t1_flags_r[T1_RUN]) begin
          if (t1_flags_r[T1_JUST]) begin
            t1_flags_nxt[T1_JUST] = 1'b0;
          end else if (t1_flags_r[T1_PEND]) begin
            t1_cnt_nxt            = t1_reload_r;
            t1_flags_nxt[T1_PEND] = 1'b0;
          end else if (t1_cnt_r != 16'h0000) begin
            t1_cnt_nxt = t1_cnt_r - 16'd1;
          end else if (acr_r[ACR_FREE]) begin
            if (t1_flags_r[T1_ARM]) ifr_nxt[IFR_T1] = 1'b1;
            t1_cnt_nxt           = t1_reload_r;
            t1_flags_nxt[T1_ARM] = 1'b1;
          end else begin
            t1_cnt_nxt            = CNT_PARK;
            t1_flags_nxt[T1_PEND] = 1'b1;
            if (t1_flags_r[T1_ARM] && !ifr_r[IFR_T1]) begin
              ifr_nxt[IFR_T1]       = 1'b1;
              t1_flags_nxt[T1_HOLD] = 1'b1;
              t1_flags_nxt[T1_ARM]  = 1'b0;
            end
          end
        end
        // timer 2, tick mode
        if (t2_flags_r[T2_RUN] && !acr_r[ACR_PULSE]) begin
          if (t2_flags_r[T2_JUST]) begin
            t2_flags_nxt[T2_JUST] = 1'b0;
          end else if (t2_cnt_r != 16'h0000) begin
            t2_cnt_nxt = t2_cnt_r - 16'd1;
          end else begin
            if (t2_flags_r[T2_ARM]) ifr_nxt[IFR_T2] = 1'b1;
            t2_cnt_nxt           = CNT_PARK;
            t2_flags_nxt[T2_ARM] = 1'b0;
          end
        end
      end

      REQ_PB6: begin
        pb6_last_nxt = item.pb6_in;
        // timer 2, pulse mode: count falling edges
        if (pb6_last_r && !item.pb6_in && acr_r[ACR_PULSE] && t2_flags_r[T2_RUN]) begin
          if (t2_cnt_r == 16'h0000) begin
            if (t2_flags_r[T2_ARM]) ifr_nxt[IFR_T2] = 1'b1;
            t2_cnt_nxt           = CNT_PARK;
            t2_flags_nxt[T2_ARM] = 1'b0;
          end else begin
            t2_cnt_nxt = t2_cnt_r - 16'd1;
          end
        end
      end
    endcase
  end

  assign result.read_data = rd;
  assign result.irq_out   = irq_calc(ifr_nxt, ier_nxt, t1_flags_nxt[T1_HOLD]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orb_r       <= 8'hFF;
      ora_r       <= '0;
      ddrb_r      <= '0;
      ddra_r      <= '0;
      t1_reload_r <= '0;
      t1_cnt_r    <= CNT_PARK;
      t1_flags_r  <= '0;
      t1_snap_r   <= '0;
      t2_reload_r <= '0;
      t2_cnt_r    <= CNT_PARK;
      t2_flags_r  <= '0;
      acr_r       <= '0;
      pcr_r       <= '0;
      sr_r        <= '0;
      ifr_r       <= '0;
      ier_r       <= '0;
      pb6_last_r  <= 1'b1;
    end else if (en) begin
      orb_r       <= orb_nxt;
      ora_r       <= ora_nxt;
      ddrb_r      <= ddrb_nxt;
      ddra_r      <= ddra_nxt;
      t1_reload_r <= t1_reload_nxt;
      t1_cnt_r    <= t1_cnt_nxt;
      t1_flags_r  <= t1_flags_nxt;
      t1_snap_r   <= t1_snap_nxt;
      t2_reload_r <= t2_reload_nxt;
      t2_cnt_r    <= t2_cnt_nxt;
      t2_flags_r  <= t2_flags_nxt;
      acr_r       <= acr_nxt;
      pcr_r       <= pcr_nxt;
      sr_r        <= sr_nxt;
      ifr_r       <= ifr_nxt;
      ier_r       <= ier_nxt;
      pb6_last_r  <= pb6_last_nxt;
    end
  end

  // the one-tick irq hold only comes with a parked one-shot timer 1
  a_hold_parked: assert property (@(posedge clk) disable iff (!rst_n)
    t1_flags_r[T1_HOLD] |-> t1_flags_r[T1_PEND] && !t1_flags_r[T1_ARM])
    else $error("t1 irq hold without parked one-shot timer");

  // hold is released by the next tick
  a_hold_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.req_type == REQ_TICK) |=> !t1_flags_r[T1_HOLD] || $rose(t1_flags_r[T1_HOLD]))
    else $error("t1 irq hold outlived a tick");

  // timers never arm without running
  a_arm_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!t1_flags_r[T1_ARM] || t1_flags_r[T1_RUN]) && (!t2_flags_r[T2_ARM] || t2_flags_r[T2_RUN]))
    else $error("timer armed while stopped");

endmodule

/* sim/versatile_interface_adapter_timers_test.sv */
`timescale 1ns / 1ps

module versatile_interface_adapter_timers_test;
  import via_pkg::*;

  // cycles with no beat on either channel before the run is called hung
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  via_req_if req_bus ();
  via_rsp_if rsp_bus ();

  versatile_interface_adapter_timers u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  // idle odds in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles;

  // results predicted for accepted beats, oldest first
  via_result_t due_results[$];

  // ---------------------------------------------------------------------
  // predicted register file and timer state
  // ---------------------------------------------------------------------
  bit [7:0]  orb_q, ora_q, ddrb_q, ddra_q, acr_q, pcr_q, sr_q;
  bit [15:0] t1_reload, t1_cnt, t2_reload, t2_cnt;
  bit [4:0]  t1_st;
  bit [8:0]  t1_snap;
  bit [2:0]  t2_st;
  bit [6:0]  ifr_q, ier_q;
  bit        pb6_q;

  task automatic clear_model();
    orb_q = 8'hFF; ora_q = '0; ddrb_q = '0; ddra_q = '0;
    acr_q = '0; pcr_q = '0; sr_q = '0;
    t1_reload = '0; t1_cnt = CNT_PARK; t1_st = '0; t1_snap = '0;
    t2_reload = '0; t2_cnt = CNT_PARK; t2_st = '0;
    ifr_q = '0; ier_q = '0; pb6_q = 1'b1;
  endtask

  // enabled flags, with the timer 1 flag hidden while the underflow hold is on
  function automatic bit irq_level();
    bit [6:0] act;
    act = ifr_q & ier_q;
    if (t1_st[T1_HOLD])
      act[IFR_T1] = 1'b0;
    return |act;
  endfunction

  function automatic void t2_underflow();
    if (t2_st[T2_ARM] && !ifr_q[IFR_T2])
      ifr_q[IFR_T2] = 1'b1;
    t2_cnt = CNT_PARK;
    t2_st[T2_ARM] = 1'b0;
  endfunction

  function automatic void t1_tick();
    if (!t1_st[T1_RUN]) begin
      // never loaded: stopped
    end else if (t1_st[T1_JUST]) begin
      t1_st[T1_JUST] = 1'b0;
    end else if (t1_st[T1_PEND]) begin
      // parked at ffff for one tick, now reload without counting
      t1_cnt = t1_reload;
      t1_st[T1_PEND] = 1'b0;
    end else if (t1_cnt != 16'd0) begin
      t1_cnt = t1_cnt - 16'd1;
    end else if (acr_q[ACR_FREE]) begin
      if (t1_st[T1_ARM] && !ifr_q[IFR_T1])
        ifr_q[IFR_T1] = 1'b1;
      t1_cnt = t1_reload;
      t1_st[T1_ARM] = 1'b1;
    end else begin
      t1_cnt = CNT_PARK;
      t1_st[T1_PEND] = 1'b1;
      if (t1_st[T1_ARM] && !ifr_q[IFR_T1]) begin
        ifr_q[IFR_T1] = 1'b1;
        t1_st[T1_HOLD] = 1'b1;
        t1_st[T1_ARM] = 1'b0;
      end
    end
  endfunction

  function automatic void t2_tick();
    if (!t2_st[T2_RUN] || acr_q[ACR_PULSE]) begin
      // stopped or counting pb6 pulses
    end else if (t2_st[T2_JUST]) begin
      t2_st[T2_JUST] = 1'b0;
    end else if (t2_cnt != 16'd0) begin
      t2_cnt = t2_cnt - 16'd1;
    end else begin
      t2_underflow();
    end
  endfunction

  function automatic bit [7:0] reg_read(logic [3:0] addr, logic [7:0] pins);
    bit [7:0] v;
    case (addr)
      ADDR_ORB:  v = orb_q;
      ADDR_ORA, ADDR_ORA_NH: v = (ora_q & ddra_q) | (pins & ~ddra_q);
      ADDR_DDRB: v = ddrb_q;
      ADDR_DDRA: v = ddra_q;
      ADDR_T1CL: begin
        // low byte read latches the high byte for the next high read
        t1_snap = {1'b1, t1_cnt[15:8]};
        ifr_q[IFR_T1] = 1'b0;
        v = t1_cnt[7:0];
      end
      ADDR_T1CH: begin
        if (t1_snap[8]) begin
          v = t1_snap[7:0];
          t1_snap[8] = 1'b0;
        end else begin
          v = t1_cnt[15:8];
        end
      end
      ADDR_T1LL: v = t1_reload[7:0];
      ADDR_T1LH: v = t1_reload[15:8];
      ADDR_T2CL: begin
        ifr_q[IFR_T2] = 1'b0;
        v = t2_cnt[7:0];
      end
      ADDR_T2CH: v = t2_cnt[15:8];
      ADDR_SR: begin
        ifr_q[IFR_SR] = 1'b0;
        v = sr_q;
      end
      ADDR_ACR: v = acr_q;
      ADDR_PCR: v = pcr_q;
      ADDR_IFR: v = {irq_level(), ifr_q};
      default:  v = {1'b1, ier_q};
    endcase
    return v;
  endfunction

  function automatic void reg_write(logic [3:0] addr, logic [7:0] d);
    case (addr)
      ADDR_ORB:  orb_q = d;
      ADDR_ORA, ADDR_ORA_NH: ora_q = d;
      ADDR_DDRB: ddrb_q = d;
      ADDR_DDRA: ddra_q = d;
      ADDR_T1CL, ADDR_T1LL: t1_reload[7:0] = d;
      ADDR_T1CH: begin
        // load and start timer 1, counting resumes one tick later
        t1_reload[15:8] = d;
        t1_cnt = t1_reload;
        t1_st = '0;
        t1_st[T1_RUN] = 1'b1;
        t1_st[T1_ARM] = 1'b1;
        t1_st[T1_JUST] = 1'b1;
        t1_snap[8] = 1'b0;
        ifr_q[IFR_T1] = 1'b0;
      end
      ADDR_T1LH: begin
        t1_reload[15:8] = d;
        ifr_q[IFR_T1] = 1'b0;
      end
      ADDR_T2CL: t2_reload[7:0] = d;
      ADDR_T2CH: begin
        t2_reload[15:8] = d;
        t2_cnt = t2_reload;
        t2_st = '0;
        t2_st[T2_RUN] = 1'b1;
        t2_st[T2_ARM] = 1'b1;
        t2_st[T2_JUST] = 1'b1;
        ifr_q[IFR_T2] = 1'b0;
      end
      ADDR_SR:   sr_q = d;
      ADDR_ACR:  acr_q = d;
      ADDR_PCR:  pcr_q = d;
      ADDR_IFR:  ifr_q = ifr_q & ~d[6:0];
      default: begin
        // bit 7 picks set or clear of the given enables
        if (d[7])
          ier_q = ier_q | d[6:0];
        else
          ier_q = ier_q & ~d[6:0];
      end
    endcase
  endfunction

  // advance the predicted state by one item and give its result beat
  function automatic via_result_t adapter_step(via_item_t it);
    via_result_t r;
    bit          prev;
    bit [15:0]   old;
    r.read_data = '0;
    case (it.req_type)
      REQ_READ:  r.read_data = reg_read(it.reg_addr, it.port_a_pins);
      REQ_WRITE: reg_write(it.reg_addr, it.write_data);
      REQ_TICK: begin
        t1_st[T1_HOLD] = 1'b0;
        t1_tick();
        t2_tick();
      end
      default: begin
        prev = pb6_q;
        pb6_q = it.pb6_in;
        // falling edge counts only in pulse mode once timer 2 is loaded
        if (prev && !it.pb6_in && acr_q[ACR_PULSE] && t2_st[T2_RUN]) begin
          old = t2_cnt;
          t2_cnt = t2_cnt - 16'd1;
          if (old == 16'd0)
            t2_underflow();
        end
      end
    endcase
    r.irq_out = irq_level();
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(input via_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= it.req_type;
    req_bus.reg_addr    <= it.reg_addr;
    req_bus.write_data  <= it.write_data;
    req_bus.port_a_pins <= it.port_a_pins;
    req_bus.pb6_in      <= it.pb6_in;
    do @(posedge clk); while (!req_bus.ready);
    due_results.push_back(adapter_step(it));
  endtask

  task automatic bus_read(input logic [3:0] addr, input logic [7:0] pins);
    send_item('{REQ_READ, addr, 8'h00, pins, 1'b0});
  endtask

  task automatic bus_write(input logic [3:0] addr, input logic [7:0] d);
    send_item('{REQ_WRITE, addr, d, 8'h00, 1'b0});
  endtask

  task automatic clock_ticks(input int n);
    repeat (n) send_item('{REQ_TICK, 4'd0, 8'h00, 8'h00, 1'b0});
  endtask

  task automatic drive_pb6(input logic level);
    send_item('{REQ_PB6, 4'd0, 8'h00, 8'h00, level});
  endtask

  // drop valid and hold off until every predicted beat has come back
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (due_results.size() != 0)
      @(posedge clk);
  endtask

  // random item, biased so that timers load small counts and underflow often
  function automatic via_item_t random_item();
    via_item_t   it;
    int unsigned pick;
    it.req_type    = REQ_TICK;
    it.reg_addr    = 4'($urandom_range(15));
    it.write_data  = 8'($urandom_range(255));
    it.port_a_pins = 8'($urandom_range(255));
    it.pb6_in      = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.req_type = REQ_TICK;
    end else if (pick < 50) begin
      it.req_type = REQ_PB6;
    end else if (pick < 72) begin
      it.req_type = REQ_READ;
    end else begin
      it.req_type = REQ_WRITE;
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(6))
          0: it.reg_addr = ADDR_T1LL;
          1: it.reg_addr = ADDR_T1CH;
          2: it.reg_addr = ADDR_T2CL;
          3: it.reg_addr = ADDR_T2CH;
          4: it.reg_addr = ADDR_ACR;
          5: it.reg_addr = ADDR_IER;
          default: it.reg_addr = ADDR_IFR;
        endcase
      end
      // keep counts short most of the time
      case (it.reg_addr)
        ADDR_T1CH, ADDR_T1LH, ADDR_T2CH:
          if ($urandom_range(99) < 80) it.write_data = 8'h00;
        ADDR_T1CL, ADDR_T1LL, ADDR_T2CL:
          if ($urandom_range(99) < 70) it.write_data = 8'($urandom_range(15));
        default: ;
      endcase
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // result side: check every beat, stall at random
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    via_result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (due_results.size() == 0) begin
        $error("result beat with none predicted: read_data %0h irq_out %0b",
               rsp_bus.read_data, rsp_bus.irq_out);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (rsp_bus.read_data !== want.read_data) begin
          $error("read_data: expected %02h, got %02h", want.read_data, rsp_bus.read_data);
          mismatches++;
        end
        if (rsp_bus.irq_out !== want.irq_out) begin
          $error("irq_out: expected %0b, got %0b", want.irq_out, rsp_bus.irq_out);
          mismatches++;
        end
      end
    end
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // hang detector: any beat on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("versatile_interface_adapter_timers_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset values, port a mixing of pins and output bits, stopped timer
  task automatic test_ports_after_reset();
    bus_read(ADDR_ORB, 8'h00);
    bus_read(ADDR_IER, 8'h00);
    clock_ticks(1);                  // nothing loaded yet, counters stay at ffff
    bus_read(ADDR_T1CH, 8'h00);
    bus_write(ADDR_DDRA, 8'hF0);
    bus_write(ADDR_ORA, 8'h5A);
    bus_read(ADDR_ORA, 8'hFF);
    bus_read(ADDR_ORA_NH, 8'h00);
  endtask

  // one-shot timer 1: load delay, underflow with irq held a tick, park, reload
  task automatic test_t1_one_shot();
    bus_write(ADDR_IER, 8'hFF);
    bus_write(ADDR_ACR, 8'h00);
    bus_write(ADDR_T1LL, 8'h01);
    bus_write(ADDR_T1CH, 8'h00);
    clock_ticks(3);
    bus_read(ADDR_IFR, 8'h00);       // flag up but irq still hidden
    clock_ticks(1);
    bus_read(ADDR_T1CL, 8'h00);      // clears flag, snapshots high byte
    bus_read(ADDR_T1CH, 8'h00);
  endtask

  // timer 2 on pb6 falling edges, then flag and enable writes
  task automatic test_t2_pulses_and_flags();
    bus_write(ADDR_T2CL, 8'h01);
    bus_write(ADDR_ACR, 8'h20);
    bus_write(ADDR_T2CH, 8'h00);
    drive_pb6(1'b0);
    drive_pb6(1'b1);
    drive_pb6(1'b0);
    bus_read(ADDR_T2CL, 8'h00);
    bus_write(ADDR_SR, 8'hFF);
    bus_write(ADDR_IFR, 8'h7F);
    bus_write(ADDR_IER, 8'h7F);      // bit 7 clear: disable all
    bus_read(ADDR_SR, 8'h00);
  endtask

  task automatic test_random(input int n, input int unsigned idle, input int unsigned stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) send_item(random_item());
  endtask

  // sender holds off completely mid-stream until everything has returned
  task automatic test_drain_pause();
    send_idle_pct = 16;
    stall_pct     = 16;
    repeat (40) send_item(random_item());
    wait_drained();
    repeat (40) send_item(random_item());
  endtask

  initial begin
    rst_n               <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_READ;
    req_bus.reg_addr    <= '0;
    req_bus.write_data  <= '0;
    req_bus.port_a_pins <= '0;
    req_bus.pb6_in      <= 1'b1;
    clear_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_ports_after_reset();
    test_t1_one_shot();
    test_t2_pulses_and_flags();
    test_random(260, 0, 0);
    test_random(260, 66, 0);
    test_random(260, 0, 66);
    test_random(180, 16, 16);
    test_drain_pause();

    // let the last beats come back, then keep clocking for strays
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("versatile_interface_adapter_timers_test: clean");
    else
      $display("versatile_interface_adapter_timers_test: errors");
    $finish;
  end

endmodule
